@@ sv/tpcd_pkg.sv @@
// Shared types, constants and the tempo scaling table of the tracker pattern cell decoder.
package tpcd_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int ROWS_DEF     = 64;

    localparam int DIV_W     = 18;
    localparam int DEN_W     = 17;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DEN_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
    } div_rsp_t;

    localparam logic CFG_FORMAT_VERSION = 1'b0;
    localparam logic CFG_MIN_BPM        = 1'b1;

    localparam logic [7:0] FORMAT_VERSION_RST = 8'd221;
    localparam logic [6:0] MIN_BPM_RST        = 7'd20;

    localparam logic [7:0] VER_1_10 = 8'd110;
    localparam logic [7:0] VER_2_00 = 8'd200;
    localparam logic [7:0] VER_2_21 = 8'd221;

    localparam logic [7:0] CODE_EMPTY_A = 8'd251;
    localparam logic [7:0] CODE_EMPTY_B = 8'd252;
    localparam logic [7:0] CODE_KEY_OFF = 8'd253;
    localparam logic [7:0] NOTE_KEY_OFF = 8'd254;
    localparam logic [7:0] NOTE_NONE    = 8'd255;

    localparam logic [1:0] NK_NONE    = 2'd0;
    localparam logic [1:0] NK_PITCH   = 2'd1;
    localparam logic [1:0] NK_KEY_OFF = 2'd2;

    localparam logic [3:0] EFF_NONE  = 4'd0;
    localparam logic [3:0] EFF_SPEED = 4'd1;
    localparam logic [3:0] EFF_BREAK = 4'd3;
    localparam logic [3:0] EFF_LAST  = 4'd10;

    localparam logic [6:0]       VOL_MAX       = 7'h40;
    localparam logic [14:0]      MIX_RATE      = 15'd23863;
    localparam logic [DIV_W-1:0] BPM_NUM       = 18'd119315;
    localparam logic [DIV_W-1:0] BPM_NO_FRAMES = 18'd125;
    localparam logic [8:0]       DIV_BASE      = 9'd50;

    function automatic logic [7:0] tick_scale(input logic [3:0] idx);
        logic [7:0] f;
        unique case (idx)
            4'd0:    f = 8'd140;
            4'd1:    f = 8'd50;
            4'd2:    f = 8'd25;
            4'd3:    f = 8'd15;
            4'd4:    f = 8'd10;
            4'd5:    f = 8'd7;
            4'd6:    f = 8'd6;
            4'd7:    f = 8'd4;
            4'd8:    f = 8'd3;
            4'd9:    f = 8'd3;
            4'd10:   f = 8'd2;
            4'd11:   f = 8'd2;
            4'd12:   f = 8'd2;
            4'd13:   f = 8'd2;
            default: f = 8'd1;
        endcase
        return f;
    endfunction

endpackage

@@ sv/tpcd_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module tpcd_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  tpcd_pkg::div_req_t  req,
    output tpcd_pkg::div_rsp_t  rsp
);

    logic [tpcd_pkg::DIV_W-1:0]     rem_reg;
    logic [tpcd_pkg::DIV_W-1:0]     quo_reg;
    logic [tpcd_pkg::DEN_W-1:0]     den_reg;
    logic [tpcd_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           done_reg;
    logic [tpcd_pkg::DIV_W:0]       diff;
    logic [tpcd_pkg::DIV_W-1:0]     shifted;

    assign shifted = {rem_reg[tpcd_pkg::DIV_W-2:0], quo_reg[tpcd_pkg::DIV_W-1]};
    assign diff    = {1'b0, shifted} - (tpcd_pkg::DIV_W + 1)'(den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
            den_reg  <= req.divisor;
            cnt_reg  <= tpcd_pkg::DIV_CNT_W'(tpcd_pkg::DIV_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[tpcd_pkg::DIV_W])
            begin
                rem_reg <= diff[tpcd_pkg::DIV_W-1:0];
                quo_reg <= {quo_reg[tpcd_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[tpcd_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == tpcd_pkg::DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ sv/tracker_pattern_cell_decoder_unit.sv @@
// Top level of the tracker pattern cell decoder: byte sequencer, speed conversion, output word.
//
// Pattern bytes enter on data_byte under in_valid/in_stall; one decoded cell leaves per
// completed cell under out_valid/out_stall, tagged with channel, row and last_of_pattern.
// Configuration (format version, tempo floor) is written through cfg_write/cfg_index/cfg_data;
// the user must write it only while the decoder is idle; the block itself does not enforce this.
// Flow: a byte that opens or continues a four-byte cell leaves in_stall low. A one-byte cell
// holds in_stall through ST_EMIT, a plain four-byte cell through ST_PREP and ST_EMIT. A speed
// cell that carries a tempo also passes ST_SETUP, ST_DIV1, ST_LAUNCH2 and ST_DIV2: up to two
// passes of the shared 18-bit restoring divider (one quotient bit a cycle), frames =
// 23863/divisor and then bpm = (119315+frames)/(2*frames).
// The output word sits in a register; new bytes are taken while it waits. A finished cell
// is held internally (in_stall high) until the receiver has taken the previous word.
// Reset clears the byte position, the channel/row counters and out_valid, and loads
// version 221 and a floor of 20 BPM.
module tracker_pattern_cell_decoder_unit
#(
    parameter int CHANNELS = tpcd_pkg::CHANNELS_DEF,
    parameter int ROWS     = tpcd_pkg::ROWS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] channel,
    output logic [5:0] row,
    output logic       last_of_pattern,
    output logic       cell_empty,
    output logic [1:0] note_kind,
    output logic [7:0] note,
    output logic [4:0] instrument,
    output logic [6:0] volume,
    output logic [3:0] effect,
    output logic [7:0] effect_param,
    output logic       has_tempo,
    output logic [6:0] tempo_bpm,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    localparam logic [1:0] LAST_CH  = 2'(CHANNELS - 1);
    localparam logic [5:0] LAST_ROW = 6'(ROWS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SETUP,
        ST_DIV1,
        ST_LAUNCH2,
        ST_DIV2,
        ST_EMIT
    } state_t;

    state_t                      state_reg;
    logic [1:0]                  pos_reg;
    logic [7:0]                  note_byte_reg;
    logic [7:0]                  inst_byte_reg;
    logic [7:0]                  eff_byte_reg;
    logic [7:0]                  param_reg;
    logic                        short_reg;
    logic                        key_off_reg;
    logic [7:0]                  spd_reg;
    logic [3:0]                  factor_reg;
    logic                        neg_reg;
    logic [15:0]                 frames_reg;
    logic [tpcd_pkg::DIV_W-1:0]  bpm_reg;
    logic [1:0]                  chan_reg;
    logic [5:0]                  row_reg;
    logic [7:0]                  version_reg;
    logic [6:0]                  min_bpm_reg;

    logic                        out_valid_reg;
    logic [1:0]                  channel_reg;
    logic [5:0]                  row_out_reg;
    logic                        last_reg;
    logic                        empty_reg;
    logic [1:0]                  note_kind_reg;
    logic [7:0]                  note_reg;
    logic [4:0]                  instrument_reg;
    logic [6:0]                  volume_reg;
    logic [3:0]                  effect_reg;
    logic [7:0]                  param_out_reg;
    logic                        has_tempo_reg;
    logic [6:0]                  tempo_reg;

    tpcd_pkg::div_req_t          div_req;
    tpcd_pkg::div_rsp_t          div_rsp;

    logic                        in_fire;
    logic                        emit_ok;
    logic                        short_code;

    logic [15:0]                 div10_prod;
    logic [7:0]                  spd10;
    logic [7:0]                  rem10;
    logic [7:0]                  spd_next;
    logic [3:0]                  factor_next;
    logic                        tempo_needed;

    logic [3:0]                  tab_idx;
    logic [11:0]                 tab_prod;
    logic [8:0]                  div_s;
    logic [8:0]                  div_mag;
    logic [15:0]                 frames_next;

    logic                        last_ch;
    logic                        last_row;
    logic [6:0]                  vol_raw;
    logic [6:0]                  vol_next;
    logic [1:0]                  note_kind_next;
    logic [7:0]                  note_next;
    logic [3:0]                  eff_nib;
    logic [3:0]                  effect_next;
    logic [7:0]                  param_next;
    logic                        has_tempo_next;
    logic [6:0]                  tempo_next;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign emit_ok    = !out_valid_reg || !out_stall;
    assign short_code = (data_byte == tpcd_pkg::CODE_EMPTY_A)
                     || (data_byte == tpcd_pkg::CODE_EMPTY_B)
                     || (data_byte == tpcd_pkg::CODE_KEY_OFF);

    // parameter / 10 by reciprocal, exact for 8-bit values
    always_comb
    begin
        div10_prod   = 16'(param_reg) * 16'd205;
        spd10        = {3'b000, div10_prod[15:11]};
        rem10        = param_reg - {spd10[4:0], 3'b000} - {spd10[6:0], 1'b0};
        tempo_needed = (eff_byte_reg[3:0] == tpcd_pkg::EFF_SPEED) && (param_reg != 8'd0)
                    && (version_reg >= tpcd_pkg::VER_1_10);
        if (version_reg >= tpcd_pkg::VER_2_21)
        begin
            spd_next    = {4'h0, param_reg[7:4]};
            factor_next = param_reg[3:0];
        end
        else if (version_reg >= tpcd_pkg::VER_1_10)
        begin
            spd_next    = spd10;
            factor_next = rem10[3:0];
        end
        else
        begin
            spd_next    = param_reg;
            factor_next = 4'h0;
        end
    end

    always_comb
    begin
        tab_idx     = (spd_reg > 8'd15) ? 4'hf : spd_reg[3:0];
        tab_prod    = 12'(tpcd_pkg::tick_scale(tab_idx)) * 12'(factor_reg);
        div_s       = tpcd_pkg::DIV_BASE - {1'b0, tab_prod[11:4]};
        div_mag     = div_s[8] ? (9'd0 - div_s) : div_s;
        frames_next = neg_reg ? (16'd0 - div_rsp.quotient[15:0]) : div_rsp.quotient[15:0];
    end

    always_comb
    begin
        div_req.start    = ((state_reg == ST_SETUP) && (div_s != 9'd0))
                        || ((state_reg == ST_LAUNCH2) && (frames_reg != 16'd0));
        if (state_reg == ST_SETUP)
        begin
            div_req.dividend = tpcd_pkg::DIV_W'(tpcd_pkg::MIX_RATE);
            div_req.divisor  = tpcd_pkg::DEN_W'(div_mag);
        end
        else
        begin
            div_req.dividend = tpcd_pkg::BPM_NUM + tpcd_pkg::DIV_W'(frames_reg);
            div_req.divisor  = {frames_reg, 1'b0};
        end
    end

    tpcd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        last_ch  = (chan_reg >= LAST_CH);
        last_row = (row_reg >= LAST_ROW);

        note_kind_next = tpcd_pkg::NK_NONE;
        note_next      = 8'd0;
        if (note_byte_reg == tpcd_pkg::NOTE_KEY_OFF)
        begin
            note_kind_next = tpcd_pkg::NK_KEY_OFF;
        end
        else if (note_byte_reg != tpcd_pkg::NOTE_NONE)
        begin
            note_kind_next = tpcd_pkg::NK_PITCH;
            note_next      = 8'd37 + 8'(note_byte_reg[3:0])
                           + 8'({4'h0, note_byte_reg[7:4]} * 8'd12);
        end

        vol_raw = 7'(inst_byte_reg[2:0]) + {eff_byte_reg[7:4], 3'b000};
        if (version_reg >= tpcd_pkg::VER_2_00)
            vol_next = (vol_raw > tpcd_pkg::VOL_MAX) ? 7'd0 : vol_raw + 7'd1;
        else if (vol_raw == 7'd0)
            vol_next = 7'd0;
        else
            vol_next = (vol_raw > tpcd_pkg::VOL_MAX) ? 7'd1 : vol_raw + 7'd1;

        eff_nib        = eff_byte_reg[3:0];
        effect_next    = eff_nib;
        param_next     = param_reg;
        has_tempo_next = 1'b0;
        tempo_next     = 7'd0;
        if ((eff_nib == tpcd_pkg::EFF_NONE) || (eff_nib > tpcd_pkg::EFF_LAST))
        begin
            effect_next = tpcd_pkg::EFF_NONE;
            param_next  = 8'd0;
        end
        else if (eff_nib == tpcd_pkg::EFF_BREAK)
        begin
            param_next = 8'd0;
        end
        else if (eff_nib == tpcd_pkg::EFF_SPEED)
        begin
            if (param_reg == 8'd0)
            begin
                effect_next = tpcd_pkg::EFF_NONE;
            end
            else
            begin
                param_next     = (spd_reg == 8'd0) ? 8'd1 : spd_reg;
                has_tempo_next = tempo_needed;
                if (tempo_needed)
                    tempo_next = (bpm_reg < tpcd_pkg::DIV_W'(min_bpm_reg))
                               ? min_bpm_reg : bpm_reg[6:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= tpcd_pkg::FORMAT_VERSION_RST;
            min_bpm_reg <= tpcd_pkg::MIN_BPM_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tpcd_pkg::CFG_FORMAT_VERSION: version_reg <= cfg_data;
                tpcd_pkg::CFG_MIN_BPM:        min_bpm_reg <= cfg_data[6:0];
                default:                      version_reg <= version_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= 2'd0;
            note_byte_reg  <= 8'd0;
            inst_byte_reg  <= 8'd0;
            eff_byte_reg   <= 8'd0;
            param_reg      <= 8'd0;
            short_reg      <= 1'b0;
            key_off_reg    <= 1'b0;
            spd_reg        <= 8'd0;
            factor_reg     <= 4'd0;
            neg_reg        <= 1'b0;
            frames_reg     <= 16'd0;
            bpm_reg        <= '0;
            chan_reg       <= 2'd0;
            row_reg        <= 6'd0;
            out_valid_reg  <= 1'b0;
            channel_reg    <= 2'd0;
            row_out_reg    <= 6'd0;
            last_reg       <= 1'b0;
            empty_reg      <= 1'b0;
            note_kind_reg  <= tpcd_pkg::NK_NONE;
            note_reg       <= 8'd0;
            instrument_reg <= 5'd0;
            volume_reg     <= 7'd0;
            effect_reg     <= tpcd_pkg::EFF_NONE;
            param_out_reg  <= 8'd0;
            has_tempo_reg  <= 1'b0;
            tempo_reg      <= 7'd0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_EMIT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (pos_reg)
                            2'd0:
                            begin
                                if (short_code)
                                begin
                                    short_reg   <= 1'b1;
                                    key_off_reg <= (data_byte == tpcd_pkg::CODE_KEY_OFF);
                                    state_reg   <= ST_EMIT;
                                end
                                else
                                begin
                                    note_byte_reg <= data_byte;
                                    pos_reg       <= 2'd1;
                                end
                            end
                            2'd1:
                            begin
                                inst_byte_reg <= data_byte;
                                pos_reg       <= 2'd2;
                            end
                            2'd2:
                            begin
                                eff_byte_reg <= data_byte;
                                pos_reg      <= 2'd3;
                            end
                            default:
                            begin
                                param_reg <= data_byte;
                                short_reg <= 1'b0;
                                pos_reg   <= 2'd0;
                                state_reg <= ST_PREP;
                            end
                        endcase
                    end
                end
                ST_PREP:
                begin
                    spd_reg    <= spd_next;
                    factor_reg <= factor_next;
                    state_reg  <= tempo_needed ? ST_SETUP : ST_EMIT;
                end
                ST_SETUP:
                begin
                    neg_reg <= div_s[8];
                    if (div_s == 9'd0)
                    begin
                        frames_reg <= 16'hffff;
                        state_reg  <= ST_LAUNCH2;
                    end
                    else
                    begin
                        state_reg <= ST_DIV1;
                    end
                end
                ST_DIV1:
                begin
                    if (div_rsp.done)
                    begin
                        frames_reg <= frames_next;
                        state_reg  <= ST_LAUNCH2;
                    end
                end
                ST_LAUNCH2:
                begin
                    if (frames_reg == 16'd0)
                    begin
                        bpm_reg   <= tpcd_pkg::BPM_NO_FRAMES;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_DIV2;
                    end
                end
                ST_DIV2:
                begin
                    if (div_rsp.done)
                    begin
                        bpm_reg   <= div_rsp.quotient;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        channel_reg   <= chan_reg;
                        row_out_reg   <= row_reg;
                        last_reg      <= last_ch && last_row;
                        if (last_ch)
                        begin
                            chan_reg <= 2'd0;
                            row_reg  <= last_row ? 6'd0 : row_reg + 6'd1;
                        end
                        else
                        begin
                            chan_reg <= chan_reg + 2'd1;
                        end
                        if (short_reg)
                        begin
                            empty_reg      <= !key_off_reg;
                            note_kind_reg  <= key_off_reg ? tpcd_pkg::NK_KEY_OFF
                                                          : tpcd_pkg::NK_NONE;
                            note_reg       <= 8'd0;
                            instrument_reg <= 5'd0;
                            volume_reg     <= 7'd0;
                            effect_reg     <= tpcd_pkg::EFF_NONE;
                            param_out_reg  <= 8'd0;
                            has_tempo_reg  <= 1'b0;
                            tempo_reg      <= 7'd0;
                        end
                        else
                        begin
                            empty_reg      <= 1'b0;
                            note_kind_reg  <= note_kind_next;
                            note_reg       <= note_next;
                            instrument_reg <= inst_byte_reg[7:3];
                            volume_reg     <= vol_next;
                            effect_reg     <= effect_next;
                            param_out_reg  <= param_next;
                            has_tempo_reg  <= has_tempo_next;
                            tempo_reg      <= tempo_next;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign channel         = channel_reg;
    assign row             = row_out_reg;
    assign last_of_pattern = last_reg;
    assign cell_empty      = empty_reg;
    assign note_kind       = note_kind_reg;
    assign note            = note_reg;
    assign instrument      = instrument_reg;
    assign volume          = volume_reg;
    assign effect          = effect_reg;
    assign effect_param    = param_out_reg;
    assign has_tempo       = has_tempo_reg;
    assign tempo_bpm       = tempo_reg;

endmodule
